>>> rtl/nsdm_pkg.sv
package nsdm_pkg;

  localparam int PIX_W = 24;
  localparam int WT_W  = 10;
  localparam int SW    = 28;   // signed direction sum
  localparam int MW    = 27;   // sum magnitude
  localparam int SQW   = 54;   // squared magnitude
  localparam int QW    = 55;   // sx^2 + sy^2
  localparam int Q25W  = 60;
  localparam int AW    = 16;   // (2c-255)^2
  localparam int LW    = 72;   // wide compare operands

  localparam logic [WT_W-1:0] WT_MAX    = 10'd765;
  localparam logic [15:0]     DIAG_Q    = 16'd23171;
  localparam int              UNIT_SH   = 15;
  localparam logic [15:0]     SCALE_SQ  = 16'd65025;
  localparam logic [Q25W-1:0] THRESH_SQ = 60'd93636 << 24;
  localparam logic [7:0]      CODE_MID  = 8'd127;

  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] prev_ch0;
    logic [7:0] prev_ch1;
    logic [7:0] prev_ch2;
    logic [7:0] curr_ch0;
    logic [7:0] curr_ch1;
    logic [7:0] curr_ch2;
  } nsdm_in_t;

  typedef struct packed {
    logic [7:0] dir_x_code;
    logic [7:0] dir_y_code;
    logic [9:0] centre_col;
    logic [9:0] centre_row;
  } nsdm_out_t;

  // 765 minus the L1 distance over three 8-bit channels
  function automatic logic [WT_W-1:0] l1_weight(input logic [PIX_W-1:0] p,
                                                input logic [PIX_W-1:0] q);
    logic [WT_W-1:0] d;
    logic [7:0]      a;
    logic [7:0]      b;
    d = '0;
    for (int i = 0; i < 3; i++) begin
      a = p[i*8 +: 8];
      b = q[i*8 +: 8];
      d = d + WT_W'((a > b) ? (a - b) : (b - a));
    end
    return WT_MAX - d;
  endfunction

endpackage

>>> rtl/nsdm_if.sv
interface nsdm_in_if import nsdm_pkg::*; ();
  logic     valid;
  logic     ready;
  nsdm_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface nsdm_out_if import nsdm_pkg::*; ();
  logic      valid;
  logic      ready;
  nsdm_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/neighbour_similarity_direction_map_unit.sv
// neighbour similarity direction map
// in_i carries one pixel pair per item (previous and current frame, same
// position) in raster order; frame_start restarts the position at row 0,
// column 0. out_o carries one direction result per interior pixel: the
// codes of the unit direction towards the most similar neighbours and the
// centre coordinates. the result for centre (r-1,c-1) follows pixel (r,c).
// cfg port: frame_width (index 0) and frame_height (index 1), written only
// while the block is idle (a rule for the user, not enforced by the block);
// values are clamped to [3, MAX]. sequence: one item at a time. an item
// past the last row is taken and dropped; an item without result does a
// line memory read, then a write back. an item with result then runs the
// exact code search, which a vector under threshold skips: 8 trial bits,
// each as square, two partial products, sum and compare, x and y in
// parallel lanes.
// line storage: one 72-bit memory of MAX_WIDTH entries (upper, middle and
// previous-frame lines), not cleared; entries are written before use.
// reset: position and window clear, registers go to 640 x 480.
// a stalled receiver holds the result in the output register; the next
// item is still taken and waits at its output step until the slot frees.
module neighbour_similarity_direction_map_unit import nsdm_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [10:0] cfg_data_i,
  nsdm_in_if.sink     in_i,
  nsdm_out_if.source  out_o
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int DW0 = (CW + 1 > 11) ? CW + 1 : 11;
  localparam int DW  = (HW > DW0) ? HW : DW0;

  typedef enum logic [13:0] {
    ST_IDLE = 14'b00000000000001,
    ST_RD   = 14'b00000000000010,
    ST_W    = 14'b00000000000100,
    ST_S    = 14'b00000000001000,
    ST_SUM  = 14'b00000000010000,
    ST_SQ   = 14'b00000000100000,
    ST_Q    = 14'b00000001000000,
    ST_T    = 14'b00000010000000,
    ST_CHK  = 14'b00000100000000,
    ST_BA   = 14'b00001000000000,
    ST_BB   = 14'b00010000000000,
    ST_BC   = 14'b00100000000000,
    ST_BD   = 14'b01000000000000,
    ST_OUT  = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [10:0] fw_q, fh_q;
  logic [DW-1:0] fwx, fhx, w_use, h_use;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= 11'd640;
      fh_q <= 11'd480;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_WIDTH:  fw_q <= cfg_data_i;
        CFG_FRAME_HEIGHT: fh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    fwx = DW'(fw_q);
    fhx = DW'(fh_q);
    if (fwx < DW'(3))                w_use = DW'(3);
    else if (fwx > DW'(MAX_WIDTH))   w_use = DW'(MAX_WIDTH);
    else                             w_use = fwx;
    if (fhx < DW'(3))                h_use = DW'(3);
    else if (fhx > DW'(MAX_HEIGHT))  h_use = DW'(MAX_HEIGHT);
    else                             h_use = fhx;
  end

  // raster position, updated at accept unless the item is past the last row
  logic [CW-1:0] col_q, col_cur, col_nxt;
  logic [HW-1:0] row_q, row_cur, row_nxt;
  logic [DW-1:0] col_inc;
  logic accept, ignore, emit, wrap;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    col_cur = in_i.data.frame_start ? '0 : col_q;
    row_cur = in_i.data.frame_start ? '0 : row_q;
    ignore  = DW'(row_cur) >= h_use;
    emit    = (DW'(col_cur) >= DW'(2)) && (DW'(row_cur) >= DW'(2));
    col_inc = DW'(col_cur) + DW'(1);
    wrap    = col_inc >= w_use;
    col_nxt = wrap ? '0 : col_inc[CW-1:0];
    row_nxt = (wrap && (DW'(row_cur) < DW'(MAX_HEIGHT))) ? row_cur + HW'(1) : row_cur;
  end

  // line memory: {prev line, curr middle, curr upper}
  logic [3*PIX_W-1:0] mem_q [MAX_WIDTH];
  logic [3*PIX_W-1:0] rd_q;
  logic [CW-1:0]      it_col_q;
  logic [PIX_W-1:0]   it_prev_q, it_cur_q;
  logic               it_emit_q;
  logic [9:0]         it_ccol_q, it_crow_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RD) begin
      mem_q[it_col_q] <= {it_prev_q, it_cur_q, rd_q[2*PIX_W-1:PIX_W]};
    end
    if (accept) begin
      rd_q <= mem_q[col_cur];
    end
  end

  // window and previous-frame centre delay
  logic [PIX_W-1:0] win_q [9];
  logic [PIX_W-1:0] pc_q  [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
      pc_q[0] <= '0;
      pc_q[1] <= '0;
    end else if (state_q == ST_RD) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r*3]   <= win_q[r*3+1];
        win_q[r*3+1] <= win_q[r*3+2];
      end
      win_q[2] <= rd_q[PIX_W-1:0];
      win_q[5] <= rd_q[2*PIX_W-1:PIX_W];
      win_q[8] <= it_cur_q;
      pc_q[1]  <= pc_q[0];
      pc_q[0]  <= rd_q[3*PIX_W-1:2*PIX_W];
    end
  end

  // arithmetic lanes: 0 is x, 1 is y
  logic [WT_W-1:0]        wt_q [8];
  logic signed [11:0]     orth [2];
  logic signed [11:0]     diag [2];
  logic signed [11:0]     orth_q [2];
  logic signed [SW-1:0]   pd_q [2];
  logic signed [SW-1:0]   s_q [2];
  logic signed [SW-1:0]   s_abs [2];
  logic                   sg_q [2];
  logic [SQW-1:0]         sq_q [2];
  logic [QW-1:0]          q_q;
  logic [43:0]            rl_q [2];
  logic [43:0]            rh_q [2];
  logic [Q25W-1:0]        q25_q;
  logic [LW-1:0]          r_q [2];
  logic [7:0]             c_q [2];
  logic [7:0]             bit_q;
  logic [7:0]             trial [2];
  logic signed [9:0]      a_s [2];
  logic signed [19:0]     a_sq [2];
  logic [AW-1:0]          asq_q [2];
  logic [44:0]            pl_q [2];
  logic [43:0]            ph_q [2];
  logic [LW-1:0]          l_q [2];
  logic                   fits [2];
  logic                   out_valid_q;
  nsdm_out_t              out_q;
  logic                   short_vec;
  logic                   out_free;

  assign out_free  = !out_valid_q || out_o.ready;
  assign short_vec = q25_q < THRESH_SQ;

  // neighbour order: ul u ur l r dl d dr
  always_comb begin
    orth[0] = $signed({2'b0, wt_q[4]}) - $signed({2'b0, wt_q[3]});
    diag[0] = $signed({2'b0, wt_q[2]}) + $signed({2'b0, wt_q[7]})
            - $signed({2'b0, wt_q[0]}) - $signed({2'b0, wt_q[5]});
    orth[1] = $signed({2'b0, wt_q[6]}) - $signed({2'b0, wt_q[1]});
    diag[1] = $signed({2'b0, wt_q[5]}) + $signed({2'b0, wt_q[7]})
            - $signed({2'b0, wt_q[0]}) - $signed({2'b0, wt_q[2]});
    for (int k = 0; k < 2; k++) begin
      s_abs[k] = s_q[k][SW-1] ? -s_q[k] : s_q[k];
      trial[k] = c_q[k] | bit_q;
      a_s[k]   = $signed({1'b0, trial[k], 1'b0}) - 10'sd255;
      a_sq[k]  = 20'(a_s[k]) * 20'(a_s[k]);
      // trial code at or below 127 means a negative scale factor
      if (!sg_q[k]) fits[k] = !trial[k][7] || (l_q[k] <= r_q[k]);
      else          fits[k] = !trial[k][7] && (r_q[k] <= l_q[k]);
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      it_col_q  <= col_cur;
      it_prev_q <= {in_i.data.prev_ch2, in_i.data.prev_ch1, in_i.data.prev_ch0};
      it_cur_q  <= {in_i.data.curr_ch2, in_i.data.curr_ch1, in_i.data.curr_ch0};
      it_emit_q <= emit;
      it_ccol_q <= 10'(col_cur - CW'(1));
      it_crow_q <= 10'(row_cur - HW'(1));
    end
    unique case (state_q)
      ST_W: begin
        for (int k = 0; k < 8; k++) begin
          wt_q[k] <= l1_weight(pc_q[1], win_q[(k < 4) ? k : k + 1]);
        end
      end
      ST_S: begin
        for (int k = 0; k < 2; k++) begin
          orth_q[k] <= orth[k];
          pd_q[k]   <= SW'(diag[k]) * SW'($signed({1'b0, DIAG_Q}));
        end
      end
      ST_SUM: begin
        for (int k = 0; k < 2; k++) s_q[k] <= (SW'(orth_q[k]) <<< UNIT_SH) + pd_q[k];
      end
      ST_SQ: begin
        for (int k = 0; k < 2; k++) begin
          sg_q[k] <= s_q[k][SW-1];
          sq_q[k] <= SQW'(s_abs[k][MW-1:0]) * SQW'(s_abs[k][MW-1:0]);
        end
      end
      ST_Q: begin
        q_q <= QW'(sq_q[0]) + QW'(sq_q[1]);
        for (int k = 0; k < 2; k++) begin
          rl_q[k] <= 44'(SCALE_SQ) * 44'(sq_q[k][26:0]);
          rh_q[k] <= 44'(SCALE_SQ) * 44'(sq_q[k][SQW-1:27]);
        end
      end
      ST_T: begin
        q25_q <= (Q25W'(q_q) << 4) + (Q25W'(q_q) << 3) + Q25W'(q_q);
        for (int k = 0; k < 2; k++) r_q[k] <= LW'(rl_q[k]) + (LW'(rh_q[k]) << 27);
      end
      ST_CHK: begin
        bit_q <= 8'h80;
        for (int k = 0; k < 2; k++) c_q[k] <= short_vec ? CODE_MID : 8'd0;
      end
      ST_BA: begin
        for (int k = 0; k < 2; k++) asq_q[k] <= a_sq[k][AW-1:0];
      end
      ST_BB: begin
        for (int k = 0; k < 2; k++) begin
          pl_q[k] <= 45'(asq_q[k]) * 45'(q_q[27:0]);
          ph_q[k] <= 44'(asq_q[k]) * 44'(q_q[QW-1:28]);
        end
      end
      ST_BC: begin
        for (int k = 0; k < 2; k++) l_q[k] <= LW'(pl_q[k]) + (LW'(ph_q[k]) << 28);
      end
      ST_BD: begin
        for (int k = 0; k < 2; k++) if (fits[k]) c_q[k] <= trial[k];
        bit_q <= bit_q >> 1;
      end
      ST_OUT: begin
        if (out_free) begin
          out_q.dir_x_code <= c_q[0];
          out_q.dir_y_code <= c_q[1];
          out_q.centre_col <= it_ccol_q;
          out_q.centre_row <= it_crow_q;
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept && !ignore) state_d = ST_RD;
      ST_RD:   state_d = it_emit_q ? ST_W : ST_IDLE;
      ST_W:    state_d = ST_S;
      ST_S:    state_d = ST_SUM;
      ST_SUM:  state_d = ST_SQ;
      ST_SQ:   state_d = ST_Q;
      ST_Q:    state_d = ST_T;
      ST_T:    state_d = ST_CHK;
      ST_CHK:  state_d = short_vec ? ST_OUT : ST_BA;
      ST_BA:   state_d = ST_BB;
      ST_BB:   state_d = ST_BC;
      ST_BC:   state_d = ST_BD;
      ST_BD:   state_d = bit_q[0] ? ST_OUT : ST_BA;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && !ignore) begin
        col_q <= col_nxt;
        row_q <= row_nxt;
      end
      if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
      else if (out_o.ready)              out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

`ifndef SYNTH
  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !ignore) |=> (state_q == ST_RD))
    else $error("accepted item did not start a line read");
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_free) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("finished result not loaded");
  a_loop_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BD && bit_q[0]) |=> (state_q == ST_OUT))
    else $error("code search did not end after last bit");
  a_short_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHK && short_vec) |=> (c_q[0] == CODE_MID && c_q[1] == CODE_MID))
    else $error("short vector not mapped to mid code");
`endif

endmodule
